// ===== src/lps_pkg.sv =====
package lps_pkg;

  localparam int COLS_BITS      = 11;
  localparam int ROWS_BITS      = 16;
  localparam int ROW_COUNT_BITS = ROWS_BITS + 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [COLS_BITS-1:0] COLS_RESET = 11'd1024;
  localparam logic [ROWS_BITS-1:0] ROWS_RESET = 16'd1024;

  // register indexes of the configuration port
  typedef enum logic [0:0] {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } cfg_reg_t;

  // what the raster position says about the item at hand
  typedef struct packed {
    logic emit;
    logic last;
  } pos_t;

endpackage

// ===== src/lps_line_ram.sv =====
module lps_line_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1026
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/lps_raster_ctrl.sv =====
module lps_raster_ctrl #(
  parameter int MAX_COLS = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  advance,
  input  logic [lps_pkg::COLS_BITS-1:0]         cols_cfg,
  input  logic [lps_pkg::ROWS_BITS-1:0]         rows_cfg,
  output logic [$clog2(MAX_COLS+2)-1:0]         col,
  output lps_pkg::pos_t                         pos
);

  localparam int CW = $clog2(MAX_COLS + 2);
  localparam int RW = lps_pkg::ROW_COUNT_BITS;

  logic [RW-1:0] row;
  logic [31:0]   cols_wide;
  logic [RW-1:0] rows_eff;
  logic          end_row;
  logic          end_grid;

  // zero acts as one, columns clamp to the buffer size
  always_comb begin
    cols_wide = (cols_cfg == '0) ? 32'd1 : 32'(cols_cfg);
    if (cols_wide > 32'(MAX_COLS)) begin
      cols_wide = 32'(MAX_COLS);
    end
    rows_eff = (rows_cfg == '0) ? RW'(1) : RW'(rows_cfg);
    end_row  = 32'(col) >= cols_wide + 32'd1;
    end_grid = end_row && (row >= rows_eff + RW'(1));
    pos.emit = (row >= RW'(2)) && (col >= CW'(2));
    pos.last = end_grid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (advance) begin
      if (end_grid) begin
        col <= '0;
        row <= '0;
      end else if (end_row) begin
        col <= '0;
        row <= row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

endmodule

// ===== src/lps_window.sv =====
module lps_window #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          commit,
  input  lps_pkg::pos_t                 pos,
  input  logic signed [SAMPLE_BITS-1:0] up,
  input  logic signed [SAMPLE_BITS-1:0] mid,
  input  logic signed [SAMPLE_BITS-1:0] here,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS+2:0] laplacian,
  output logic                          out_last
);

  localparam int OW = SAMPLE_BITS + 3;

  // column c-1: north, centre, south; column c-2: centre row only
  logic signed [SAMPLE_BITS-1:0] north;
  logic signed [SAMPLE_BITS-1:0] centre;
  logic signed [SAMPLE_BITS-1:0] south;
  logic signed [SAMPLE_BITS-1:0] west;
  logic signed [OW-1:0]          lap_next;

  always_comb begin
    lap_next = (OW'(centre) <<< 2) - OW'(north) - OW'(south) - OW'(west) - OW'(mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      north  <= '0;
      centre <= '0;
      south  <= '0;
      west   <= '0;
    end else if (commit) begin
      north  <= up;
      centre <= mid;
      south  <= here;
      west   <= centre;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit && pos.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit && pos.emit) begin
      laplacian <= lap_next;
      out_last  <= pos.last;
    end
  end

endmodule

// ===== src/laplace_5point_stencil.sv =====
// five-point laplacian over a bordered grid streamed in raster order
// a result is registered at the output after the sample completing it leaves stage two
// throughput: one sample per cycle unless stalled by out_ready; one read, one write per ram
// reset: counters, window and valid flags cleared, sizes back to 1024 by 1024
// line rams are not cleared; entries read before their first write feed only border rows
module laplace_5point_stencil #(
  parameter int MAX_COLS    = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample stream
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample,
  // result stream
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS+2:0]         laplacian,
  output logic                                  last,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [0:0]                            cfg_index,
  input  logic [lps_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int DEPTH = MAX_COLS + 2;
  localparam int CW    = $clog2(DEPTH);

  // configuration registers
  logic [lps_pkg::COLS_BITS-1:0] cols_cfg;
  logic [lps_pkg::ROWS_BITS-1:0] rows_cfg;

  // raster position of the sample being offered
  logic [CW-1:0]  col;
  lps_pkg::pos_t  pos;

  // second stage: sample waiting for its line ram data
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic [CW-1:0]                 s1_col;
  lps_pkg::pos_t                 s1_pos;
  logic                          s1_go;

  // line ram read data, lined up with the second stage
  logic signed [SAMPLE_BITS-1:0] rd_up;
  logic signed [SAMPLE_BITS-1:0] rd_mid;

  logic in_fire;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= lps_pkg::COLS_RESET;
      rows_cfg <= lps_pkg::ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lps_pkg::cfg_reg_t'(cfg_index))
        lps_pkg::REG_COLS: cols_cfg <= cfg_data[lps_pkg::COLS_BITS-1:0];
        lps_pkg::REG_ROWS: rows_cfg <= cfg_data[lps_pkg::ROWS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // the second stage retires once the output register can take its result;
  // border samples have no result and always retire
  assign s1_go    = s1_valid && (!s1_pos.emit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;
  assign in_fire  = in_valid && in_ready;

  lps_raster_ctrl #(
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .advance  (in_fire),
    .cols_cfg (cols_cfg),
    .rows_cfg (rows_cfg),
    .col      (col),
    .pos      (pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= sample;
      s1_col    <= col;
      s1_pos    <= pos;
    end
  end

  // read at transfer, write back at retire; a column address comes round again
  // only after at least three samples, so the write always lands before the
  // next read of that entry and no bypass is needed
  lps_line_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_upper (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col),
    .rd_data (rd_up),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (rd_mid)
  );

  lps_line_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_middle (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col),
    .rd_data (rd_mid),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (s1_sample)
  );

  // window shift, stencil sum and output register
  lps_window #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .commit    (s1_go),
    .pos       (s1_pos),
    .up        (rd_up),
    .mid       (rd_mid),
    .here      (s1_sample),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .laplacian (laplacian),
    .out_last  (last)
  );

  // an empty second stage never holds off the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> in_ready)
    else $error("input held off with the second stage empty");

  // a retiring interior sample always leaves a result behind
  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_pos.emit |=> out_valid)
    else $error("interior sample retired without a result");

  // write-back and a new read never meet on the same line ram entry
  a_no_collision: assert property (@(posedge clk) disable iff (rst)
    s1_go && in_fire |-> s1_col != col)
    else $error("line ram read and write at the same entry");

  // a stalled second stage keeps its position
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_go |=> s1_valid && $stable(s1_col) && $stable(s1_pos))
    else $error("stalled second stage lost its contents");

endmodule
